@@ hdl/mlss_pkg.sv @@
// Shared types and constants for the move list score sorter.
// Used by mlss_ctrl, mlss_dpath and move_list_score_sorter_top; no dependencies.
`timescale 1ns / 1ps

package mlss_pkg;

	localparam int MAX_ENTRIES_DEF  = 256;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int OP_W    = 3;
	localparam int KEY_W   = 16;
	localparam int WORD_W  = 32;
	localparam int SCORE_W = 32;
	localparam int POS_W   = 8;
	localparam int RES_W   = 2;
	localparam int CNT_W   = 9;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR    = 3'd0,
		OP_APPEND   = 3'd1,
		OP_SORT_ALL = 3'd2,
		OP_SORT_POS = 3'd3,
		OP_FIND     = 3'd4,
		OP_READ     = 3'd5
	} op_t;

	typedef enum logic [RES_W-1:0] {
		RES_OK        = 2'd0,
		RES_NOT_FOUND = 2'd1,
		RES_BAD       = 2'd2
	} res_t;

	typedef enum logic [1:0] {
		BASE_HOLD = 2'd0,
		BASE_ZERO = 2'd1,
		BASE_POS  = 2'd2,
		BASE_NEXT = 2'd3
	} base_sel_t;

	typedef enum logic [1:0] {
		WR_APPEND = 2'd0,
		WR_BASE   = 2'd1,
		WR_BEST   = 2'd2
	} wr_sel_t;

	typedef struct packed {
		logic      capture;
		logic      clear;
		logic      count_inc;
		logic      wr_en;
		wr_sel_t   wr_sel;
		logic      scan_start;
		base_sel_t base_sel;
		logic      end_one;
		logic      scan_step;
		logic      load_result;
		res_t      res;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic scan_busy;
		logic swap_needed;
		logic more_bases;
		logic pos_bad;
		logic table_full;
		logic two_plus;
		logic hit;
		logic out_free;
	} sts_t;

endpackage

@@ hdl/move_list_score_sorter_top.sv @@
// Top level of the move list score sorter: joins the sequencer and the datapath.
// Depends on mlss_pkg, mlss_ctrl and mlss_dpath.
`timescale 1ns / 1ps

// The block keeps a table of up to MAX_ENTRIES entries (key, payload, signed score) in one
// memory with a registered read, and takes one item at a time; every item gives exactly
// one result. Clear, append, rejected items, unused codes and a sort all with fewer than two
// entries need no scan; read fetches the one entry at its position; find scans every entry;
// sort from position p scans from p to the end, and a full sort scans from each position in
// turn up to the next to last; each swap adds two writes. The memory port reads one entry
// per cycle during a scan. The block is ready for the next item as soon as the result appears
// at the output. A new item is taken while the previous result still waits at the output.

module move_list_score_sorter_top
	import mlss_pkg::*;
#(
	parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [OP_W-1:0]           operation,
	input  logic [KEY_W-1:0]          move_key,
	input  logic [WORD_W-1:0]         move_word,
	input  logic signed [SCORE_W-1:0] score,
	input  logic [POS_W-1:0]          position,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [RES_W-1:0]          status,
	output logic [POS_W-1:0]          found_position,
	output logic [KEY_W-1:0]          key_out,
	output logic [WORD_W-1:0]         word_out,
	output logic signed [SCORE_W-1:0] score_out,
	output logic [CNT_W-1:0]          entry_count
);

	cmd_t cmd;
	sts_t sts;

	mlss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mlss_dpath #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.move_key       (move_key),
		.move_word      (move_word),
		.score          (score),
		.position       (position),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.status         (status),
		.found_position (found_position),
		.key_out        (key_out),
		.word_out       (word_out),
		.score_out      (score_out),
		.entry_count    (entry_count)
	);

endmodule

@@ hdl/mlss_ctrl.sv @@
// Sequencer for the move list score sorter: decodes each item and steps the datapath.
// Depends on mlss_pkg.
`timescale 1ns / 1ps

module mlss_ctrl
	import mlss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_SCAN     = 6'b000100,
		S_SWAP_A   = 6'b001000,
		S_SWAP_B   = 6'b010000,
		S_DONE     = 6'b100000
	} state_t;

	state_t state_q, state_d;
	res_t   res_q, res_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				res_d   = RES_OK;
				state_d = S_DONE;
				case (sts.op)
					OP_CLEAR: begin
						cmd.clear = 1'b1;
					end
					OP_APPEND: begin
						if (sts.table_full) begin
							res_d = RES_BAD;
						end else begin
							cmd.wr_en     = 1'b1;
							cmd.wr_sel    = WR_APPEND;
							cmd.count_inc = 1'b1;
						end
					end
					OP_SORT_ALL: begin
						if (sts.two_plus) begin
							cmd.scan_start = 1'b1;
							cmd.base_sel   = BASE_ZERO;
							state_d        = S_SCAN;
						end
					end
					OP_SORT_POS: begin
						if (sts.pos_bad) begin
							res_d = RES_BAD;
						end else begin
							cmd.scan_start = 1'b1;
							cmd.base_sel   = BASE_POS;
							state_d        = S_SCAN;
						end
					end
					OP_FIND: begin
						cmd.scan_start = 1'b1;
						cmd.base_sel   = BASE_ZERO;
						state_d        = S_SCAN;
					end
					OP_READ: begin
						if (sts.pos_bad) begin
							res_d = RES_BAD;
						end else begin
							cmd.scan_start = 1'b1;
							cmd.base_sel   = BASE_POS;
							cmd.end_one    = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: begin
						// unused codes: no change, plain ok
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (!sts.scan_busy) begin
					case (sts.op)
						OP_FIND: begin
							res_d   = sts.hit ? RES_OK : RES_NOT_FOUND;
							state_d = S_DONE;
						end
						OP_SORT_ALL, OP_SORT_POS: begin
							if (sts.swap_needed) begin
								state_d = S_SWAP_A;
							end else if (sts.op == OP_SORT_ALL && sts.more_bases) begin
								cmd.scan_start = 1'b1;
								cmd.base_sel   = BASE_NEXT;
								state_d        = S_SCAN;
							end else begin
								state_d = S_DONE;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_SWAP_A: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_BASE;
				state_d    = S_SWAP_B;
			end
			S_SWAP_B: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_BEST;
				// advance to the next position of a full sort
				if (sts.op == OP_SORT_ALL && sts.more_bases) begin
					cmd.scan_start = 1'b1;
					cmd.base_sel   = BASE_NEXT;
					state_d        = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= RES_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

@@ hdl/mlss_dpath.sv @@
// Datapath of the move list score sorter: entry memory, scan pipeline, best tracking
// and output register. Depends on mlss_pkg.
`timescale 1ns / 1ps

module mlss_dpath
	import mlss_pkg::*;
#(
	parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic [OP_W-1:0]           operation,
	input  logic [KEY_W-1:0]          move_key,
	input  logic [WORD_W-1:0]         move_word,
	input  logic signed [SCORE_W-1:0] score,
	input  logic [POS_W-1:0]          position,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [RES_W-1:0]          status,
	output logic [POS_W-1:0]          found_position,
	output logic [KEY_W-1:0]          key_out,
	output logic [WORD_W-1:0]         word_out,
	output logic signed [SCORE_W-1:0] score_out,
	output logic [CNT_W-1:0]          entry_count
);

	localparam int WB   = (PAYLOAD_BITS < WORD_W) ? PAYLOAD_BITS : WORD_W;
	localparam int EW   = KEY_W + WB + SCORE_W;
	localparam int AW   = $clog2(MAX_ENTRIES);
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CW1  = CW + 1;
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [EW-1:0] mem [MAX_ENTRIES];

	op_t                op_q;
	logic [KEY_W-1:0]   key_in_q;
	logic [WB-1:0]      word_in_q;
	logic [SCORE_W-1:0] score_in_q;
	logic [POS_W-1:0]   pos_q;

	logic [CW-1:0] count_q;
	logic [AW-1:0] base_q, base_nxt;
	logic [CW-1:0] idx_q, end_q;
	logic          rd_en;

	logic [EW-1:0] rd_data_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          rd_vld_s1;

	logic [EW-1:0] best_q, base_ent_q;
	logic [AW-1:0] best_idx_q;
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic          out_valid_q;
	logic          out_free;

	always_comb begin
		case (cmd.base_sel)
			BASE_ZERO: base_nxt = '0;
			BASE_POS:  base_nxt = AW'(pos_q);
			BASE_NEXT: base_nxt = base_q + AW'(1);
			default:   base_nxt = base_q;
		endcase
	end

	assign rd_en = cmd.scan_step && (idx_q < end_q);

	always_comb begin
		wr_en = cmd.wr_en;
		case (cmd.wr_sel)
			WR_APPEND: begin
				wr_addr = count_q[AW-1:0];
				wr_data = {key_in_q, word_in_q, score_in_q};
			end
			WR_BASE: begin
				wr_addr = base_q;
				wr_data = best_q;
			end
			WR_BEST: begin
				wr_addr = best_idx_q;
				wr_data = base_ent_q;
			end
			default: begin
				wr_en   = 1'b0;
				wr_addr = base_q;
				wr_data = best_q;
			end
		endcase
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end
			rd_vld_s1 <= rd_en;
			if (cmd.scan_start) begin
				hit_q <= 1'b0;
			end else if (rd_vld_s1 && !hit_q
			             && rd_data_s1[EW-1 -: KEY_W] == key_in_q) begin
				hit_q <= 1'b1;
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= op_t'(operation);
			key_in_q   <= move_key;
			word_in_q  <= move_word[WB-1:0];
			score_in_q <= score;
			pos_q      <= position;
		end
		if (cmd.scan_start) begin
			base_q <= base_nxt;
			idx_q  <= CW'(base_nxt);
			end_q  <= cmd.end_one ? (CW'(base_nxt) + CW'(1)) : count_q;
		end else if (rd_en) begin
			idx_q <= idx_q + CW'(1);
		end
		if (rd_en) begin
			rd_idx_s1 <= idx_q[AW-1:0];
		end
		if (rd_vld_s1) begin
			// first entry of the scan seeds the maximum; ties keep the earlier one
			if (rd_idx_s1 == base_q) begin
				best_q     <= rd_data_s1;
				best_idx_q <= rd_idx_s1;
				base_ent_q <= rd_data_s1;
			end else if ($signed(best_q[SCORE_W-1:0]) < $signed(rd_data_s1[SCORE_W-1:0])) begin
				best_q     <= rd_data_s1;
				best_idx_q <= rd_idx_s1;
			end
			if (!hit_q) begin
				hit_idx_q <= rd_idx_s1;
			end
		end
		if (cmd.load_result) begin
			status         <= cmd.res;
			entry_count    <= CNT_W'(count_q);
			found_position <= '0;
			key_out        <= '0;
			word_out       <= '0;
			score_out      <= '0;
			if (cmd.res == RES_OK && op_q == OP_FIND) begin
				found_position <= POS_W'(hit_idx_q);
			end
			if (cmd.res == RES_OK && op_q == OP_READ) begin
				key_out   <= base_ent_q[EW-1 -: KEY_W];
				word_out  <= WORD_W'(base_ent_q[SCORE_W +: WB]);
				score_out <= base_ent_q[SCORE_W-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.op          = op_q;
		sts.scan_busy   = (idx_q < end_q) || rd_vld_s1;
		sts.swap_needed = (best_idx_q != base_q);
		sts.more_bases  = (CW1'(base_q) + CW1'(2)) < CW1'(count_q);
		sts.pos_bad     = CMPW'(pos_q) >= CMPW'(count_q);
		sts.table_full  = count_q >= CW'(MAX_ENTRIES);
		sts.two_plus    = count_q > CW'(1);
		sts.hit         = hit_q;
		sts.out_free    = out_free;
	end

endmodule

@@ test/tb_move_list_score_sorter_top.sv @@
// Self-checking testbench for move_list_score_sorter_top: directed and random operations on the
// entry table, each result checked against a predictor of the table kept in the testbench.
// Depends on mlss_pkg and the move_list_score_sorter_top RTL.
`timescale 1ns / 1ps

module tb_move_list_score_sorter_top;
	import mlss_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam int ITEM_TARGET    = 1900;
	localparam int RESET_CYCLES   = 11;
	localparam int HOLDOFF_AT     = 400;
	localparam int HOLDOFF_CYCLES = 1000;
	localparam int DRAIN_CYCLES   = 64;
	// must outlast a full sort of a full table, during which nothing is accepted
	localparam int IDLE_LIMIT     = 200000;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic [KEY_W-1:0]          key;
		logic [WORD_W-1:0]         word;
		logic signed [SCORE_W-1:0] score;
		logic [POS_W-1:0]          pos;
	} move_op_t;

	typedef struct packed {
		logic [RES_W-1:0]          status;
		logic [POS_W-1:0]          found;
		logic [KEY_W-1:0]          key;
		logic [WORD_W-1:0]         word;
		logic signed [SCORE_W-1:0] score;
		logic [CNT_W-1:0]          count;
	} move_res_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [OP_W-1:0]           operation = '0;
	logic [KEY_W-1:0]          move_key = '0;
	logic [WORD_W-1:0]         move_word = '0;
	logic signed [SCORE_W-1:0] score = '0;
	logic [POS_W-1:0]          position = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [RES_W-1:0]          status;
	logic [POS_W-1:0]          found_position;
	logic [KEY_W-1:0]          key_out;
	logic [WORD_W-1:0]         word_out;
	logic signed [SCORE_W-1:0] score_out;
	logic [CNT_W-1:0]          entry_count;

	move_list_score_sorter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.move_key(move_key),
		.move_word(move_word),
		.score(score),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found_position(found_position),
		.key_out(key_out),
		.word_out(word_out),
		.score_out(score_out),
		.entry_count(entry_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted contents of the entry table
	logic [KEY_W-1:0]          stored_key [MAX_ENTRIES_DEF];
	logic [WORD_W-1:0]         stored_word [MAX_ENTRIES_DEF];
	logic signed [SCORE_W-1:0] stored_score [MAX_ENTRIES_DEF];
	int                        stored_count = 0;
	int                        peak_count = 0;

	move_op_t  pending_moves [$];
	move_res_t predicted_results [$];
	logic [KEY_W-1:0] queued_keys [$];   // keys the stimulus has put in the table so far

	int moves_queued = 0;
	int real_queued = 0;
	int moves_taken = 0;
	int results_seen = 0;
	int error_count = 0;
	int op_seen [8];

	// one selection step: bring the first largest score at or after k to position k
	function automatic void select_into(int k);
		int best;
		logic [KEY_W-1:0]          tk;
		logic [WORD_W-1:0]         tw;
		logic signed [SCORE_W-1:0] ts;
		best = k;
		for (int i = k + 1; i < stored_count; i++)
			if (stored_score[i] > stored_score[best])
				best = i;
		if (best != k) begin
			tk = stored_key[k];
			tw = stored_word[k];
			ts = stored_score[k];
			stored_key[k] = stored_key[best];
			stored_word[k] = stored_word[best];
			stored_score[k] = stored_score[best];
			stored_key[best] = tk;
			stored_word[best] = tw;
			stored_score[best] = ts;
		end
	endfunction

	function automatic move_res_t apply_move_op(move_op_t m);
		move_res_t r;
		r = '0;
		case (m.op)
			OP_CLEAR: stored_count = 0;
			OP_APPEND: begin
				if (stored_count >= MAX_ENTRIES_DEF) begin
					r.status = RES_BAD;
				end else begin
					stored_key[stored_count] = m.key;
					stored_word[stored_count] = m.word;
					stored_score[stored_count] = m.score;
					stored_count++;
				end
			end
			OP_SORT_ALL: begin
				for (int k = 0; k + 1 < stored_count; k++)
					select_into(k);
			end
			OP_SORT_POS: begin
				if (int'(m.pos) >= stored_count)
					r.status = RES_BAD;
				else
					select_into(int'(m.pos));
			end
			OP_FIND: begin
				r.status = RES_NOT_FOUND;
				// scan downward so the first match is the one left standing
				for (int i = stored_count - 1; i >= 0; i--) begin
					if (stored_key[i] == m.key) begin
						r.status = RES_OK;
						r.found = POS_W'(i);
					end
				end
			end
			OP_READ: begin
				if (int'(m.pos) >= stored_count) begin
					r.status = RES_BAD;
				end else begin
					r.key = stored_key[m.pos];
					r.word = stored_word[m.pos];
					r.score = stored_score[m.pos];
				end
			end
			default: ;
		endcase
		r.count = CNT_W'(stored_count);
		return r;
	endfunction

	function automatic int pick_pause(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return KEY_W'($urandom_range(0, 15));
		if (r < 55)
			return '1;
		if (r < 60)
			return '0;
		return KEY_W'($urandom);
	endfunction

	function automatic logic signed [SCORE_W-1:0] rand_score();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 32'h7FFF_FFFF;
		if (r < 16)
			return 32'h8000_0000;
		if (r < 24)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		if (r < 55)
			return $signed(SCORE_W'($urandom_range(0, 8))) - 4;   // narrow range: many ties
		return SCORE_W'($urandom);
	endfunction

	// mostly a position inside the table, sometimes anywhere
	function automatic logic [POS_W-1:0] pick_pos();
		if (queued_keys.size() > 0 && $urandom_range(0, 9) < 8)
			return POS_W'($urandom_range(0, queued_keys.size() - 1));
		return POS_W'($urandom);
	endfunction

	function automatic logic [KEY_W-1:0] pick_find_key();
		if (queued_keys.size() > 0 && $urandom_range(0, 9) < 7)
			return queued_keys[$urandom_range(0, queued_keys.size() - 1)];
		return rand_key();
	endfunction

	task automatic push_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [WORD_W-1:0] word, input logic signed [SCORE_W-1:0] sc,
			input logic [POS_W-1:0] pos);
		move_op_t m;
		m.op = op;
		m.key = key;
		m.word = word;
		m.score = sc;
		m.pos = pos;
		pending_moves.push_back(m);
		moves_queued++;
		if (op <= OP_READ)
			real_queued++;
		if (op == OP_CLEAR)
			queued_keys.delete();
		else if (op == OP_APPEND && queued_keys.size() < MAX_ENTRIES_DEF)
			queued_keys.push_back(key);
	endtask

	task automatic report_error(input string msg);
		error_count++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got %h, want %h", results_seen, name,
				got, want));
	endtask

	// driver
	move_op_t on_bus;
	int       send_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0;
			move_key <= '0;
			move_word <= '0;
			score <= '0;
			position <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				predicted_results.push_back(apply_move_op(on_bus));
				if (stored_count > peak_count)
					peak_count = stored_count;
				op_seen[on_bus.op]++;
				moves_taken++;
				send_gap = pick_pause(((moves_taken / 160) % 5) == 3);
			end
			// hold the offered item until it is taken
			if (!(in_valid && !in_ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_moves.size() > 0) begin
					on_bus = pending_moves.pop_front();
					operation <= on_bus.op;
					move_key <= on_bus.key;
					move_word <= on_bus.word;
					score <= on_bus.score;
					position <= on_bus.pos;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int stall_left = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;

	task automatic check_result();
		move_res_t want;
		if (predicted_results.size() == 0) begin
			report_error($sformatf("result %0d arrived with nothing pending", results_seen));
		end else begin
			want = predicted_results.pop_front();
			check_field("status", 32'(status), 32'(want.status));
			check_field("found_position", 32'(found_position), 32'(want.found));
			check_field("key_out", 32'(key_out), 32'(want.key));
			check_field("word_out", word_out, want.word);
			check_field("score_out", score_out, want.score);
			check_field("entry_count", 32'(entry_count), 32'(want.count));
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			holdoff_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				check_result();
				stall_left = pick_pause(((results_seen / 190) % 5) == 1);
			end
			// long hold-off once, so the block backs up and stalls its input
			if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int  n;
		int  r;
		bit  big_done;
		bit  mid_done;

		big_done = 1'b0;
		mid_done = 1'b0;

		// directed: empty table, extremes, ties, duplicate keys, unused codes
		push_op(OP_READ, rand_key(), WORD_W'($urandom), rand_score(), 8'd0);
		push_op(OP_FIND, 16'd0, WORD_W'($urandom), rand_score(), POS_W'($urandom));
		push_op(OP_SORT_ALL, rand_key(), WORD_W'($urandom), rand_score(), POS_W'($urandom));
		push_op(OP_SORT_POS, rand_key(), WORD_W'($urandom), rand_score(), 8'd0);
		push_op(OP_SPARE_LO, rand_key(), WORD_W'($urandom), rand_score(), POS_W'($urandom));
		push_op(OP_SPARE_HI, '1, '1, '1, '1);
		push_op(OP_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 8'hFF);
		push_op(OP_SORT_ALL, rand_key(), WORD_W'($urandom), rand_score(), POS_W'($urandom));
		push_op(OP_APPEND, 16'h0000, 32'h0000_0000, 32'h7FFF_FFFF, 8'h00);
		push_op(OP_APPEND, 16'h1234, 32'hA5A5_A5A5, 32'h0000_0000, 8'h55);
		push_op(OP_APPEND, 16'h1234, 32'h5A5A_5A5A, 32'h0000_0000, 8'hAA);
		push_op(OP_APPEND, 16'h0007, 32'h0000_0001, 32'hFFFF_FFFF, 8'h01);
		push_op(OP_APPEND, 16'h0008, 32'h0000_0002, 32'h7FFF_FFFF, 8'h02);
		push_op(OP_FIND, 16'h1234, WORD_W'($urandom), rand_score(), POS_W'($urandom));
		push_op(OP_FIND, 16'hBEEF, WORD_W'($urandom), rand_score(), POS_W'($urandom));
		push_op(OP_SORT_POS, rand_key(), WORD_W'($urandom), rand_score(), 8'd4);
		push_op(OP_SORT_POS, rand_key(), WORD_W'($urandom), rand_score(), 8'd6);
		push_op(OP_SORT_POS, rand_key(), WORD_W'($urandom), rand_score(), 8'd255);
		push_op(OP_SORT_ALL, rand_key(), WORD_W'($urandom), rand_score(), POS_W'($urandom));
		for (int p = 0; p <= 6; p += 3)
			push_op(OP_READ, rand_key(), WORD_W'($urandom), rand_score(), POS_W'(p));
		push_op(OP_READ, rand_key(), WORD_W'($urandom), rand_score(), 8'd255);
		push_op(OP_SORT_POS, rand_key(), WORD_W'($urandom), rand_score(), 8'd0);
		push_op(OP_CLEAR, rand_key(), WORD_W'($urandom), rand_score(), POS_W'($urandom));
		push_op(OP_READ, rand_key(), WORD_W'($urandom), rand_score(), 8'd0);

		while (real_queued < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (!big_done && real_queued >= 800) begin
				// fill the table to the top, overflow it, and sort it twice
				big_done = 1'b1;
				push_op(OP_CLEAR, rand_key(), WORD_W'($urandom), rand_score(), POS_W'($urandom));
				for (int i = 0; i < MAX_ENTRIES_DEF; i++)
					push_op(OP_APPEND, KEY_W'(i), WORD_W'($urandom), rand_score(),
						POS_W'($urandom));
				push_op(OP_APPEND, rand_key(), WORD_W'($urandom), rand_score(), POS_W'($urandom));
				push_op(OP_FIND, 16'd255, WORD_W'($urandom), rand_score(), POS_W'($urandom));
				push_op(OP_READ, rand_key(), WORD_W'($urandom), rand_score(), 8'd255);
				push_op(OP_SORT_ALL, rand_key(), WORD_W'($urandom), rand_score(), '0);
				push_op(OP_READ, rand_key(), WORD_W'($urandom), rand_score(), 8'd0);
				push_op(OP_READ, rand_key(), WORD_W'($urandom), rand_score(), 8'd255);
				push_op(OP_FIND, pick_find_key(), WORD_W'($urandom), rand_score(), '0);
				push_op(OP_SORT_POS, rand_key(), WORD_W'($urandom), rand_score(), 8'd254);
				push_op(OP_SORT_POS, rand_key(), WORD_W'($urandom), rand_score(), 8'd255);
				push_op(OP_SORT_ALL, rand_key(), WORD_W'($urandom), rand_score(), '0);
				push_op(OP_READ, rand_key(), WORD_W'($urandom), rand_score(), pick_pos());
				push_op(OP_CLEAR, rand_key(), WORD_W'($urandom), rand_score(), POS_W'($urandom));
			end else if (r < 85) begin
				// well-formed: build a small table, then work on it
				if (r < 65 || queued_keys.size() > 60)
					push_op(OP_CLEAR, rand_key(), WORD_W'($urandom), rand_score(),
						POS_W'($urandom));
				n = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 10) : $urandom_range(11, 40);
				if (!mid_done && real_queued >= 1400) begin
					mid_done = 1'b1;
					n = 64;
				end
				repeat (n)
					push_op(OP_APPEND, rand_key(), WORD_W'($urandom), rand_score(),
						POS_W'($urandom));
				repeat ($urandom_range(3, 12)) begin
					r = $urandom_range(0, 99);
					if (r < 18)
						push_op(OP_SORT_ALL, rand_key(), WORD_W'($urandom), rand_score(),
							POS_W'($urandom));
					else if (r < 38)
						push_op(OP_SORT_POS, rand_key(), WORD_W'($urandom), rand_score(),
							pick_pos());
					else if (r < 58)
						push_op(OP_FIND, pick_find_key(), WORD_W'($urandom), rand_score(),
							POS_W'($urandom));
					else if (r < 88)
						push_op(OP_READ, rand_key(), WORD_W'($urandom), rand_score(),
							pick_pos());
					else
						push_op(OP_APPEND, rand_key(), WORD_W'($urandom), rand_score(),
							POS_W'($urandom));
				end
			end else begin
				// noise: any code, any fields
				repeat ($urandom_range(1, 6))
					push_op(OP_W'($urandom_range(0, 7)), rand_key(), WORD_W'($urandom),
						rand_score(), POS_W'($urandom));
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (moves_taken < moves_queued) @(posedge clk);
		while (predicted_results.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d items, %0d results; clear %0d, append %0d, sort all %0d, sort from %0d",
			moves_taken, results_seen, op_seen[OP_CLEAR], op_seen[OP_APPEND],
			op_seen[OP_SORT_ALL], op_seen[OP_SORT_POS]);
		$display("Summary: find %0d, read %0d, unused codes %0d; peak of %0d entries, %0d-cycle output hold-off",
			op_seen[OP_FIND], op_seen[OP_READ], op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI],
			peak_count, HOLDOFF_CYCLES);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
